[design/convex_polygon_fan_triangulate_defines.svh]
// Assertion macros of the checker of the fan triangulator.
`ifndef CONVEX_POLYGON_FAN_TRIANGULATE_DEFINES_SVH
`define CONVEX_POLYGON_FAN_TRIANGULATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CPFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CPFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cpft_pkg.sv]
// Types and constants of the convex polygon fan triangulator.
package cpft_pkg;

    localparam int CoordW      = 24;
    localparam int ColourW     = 32;
    localparam int MinVertices = 3;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef enum logic [1:0] {
        ST_TRI      = 2'd0,
        ST_REJECT   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [CoordW-1:0] vertex_along;
        logic signed [CoordW-1:0] vertex_across;
        logic                     vertex_last;
    } t_vertex_in;

    typedef struct packed {
        logic signed [CoordW-1:0] first_along;
        logic signed [CoordW-1:0] first_across;
        logic signed [CoordW-1:0] second_along;
        logic signed [CoordW-1:0] second_across;
        logic signed [CoordW-1:0] third_along;
        logic signed [CoordW-1:0] third_across;
        logic [ColourW-1:0]       colour;
        t_status                  status;
        logic                     run_last;
    } t_result;

    // One stored vertex.
    typedef struct packed {
        logic signed [CoordW-1:0] along;
        logic signed [CoordW-1:0] across;
    } t_vertex;

    // Sample tags from the sequencer to the geometry pipeline.
    typedef struct packed {
        logic clear;
        logic sample;
        logic area;
        logic turn;
    } t_geom_ctl;

    typedef struct packed {
        logic idle;
        logic convex;
        logic area_neg;
    } t_geom_res;

    typedef enum logic [2:0] {
        S_LOAD,
        S_WALK,
        S_DRAIN,
        S_EMIT,
        S_TAIL,
        S_OVF,
        S_REJECT
    } t_state;

endpackage

[design/cpft_vstore.sv]
// Vertex store: one write port, one read port, registered read data.
module cpft_vstore #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  cpft_pkg::t_vertex i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output cpft_pkg::t_vertex o_rd_data
);

    cpft_pkg::t_vertex mem [DEPTH];
    cpft_pkg::t_vertex r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

[design/cpft_geom.sv]
// Geometry pipeline: edge cross products, sign tracking and signed area sum.
module cpft_geom #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpft_pkg::t_geom_ctl i_ctl,
    input  cpft_pkg::t_vertex   i_vtx,
    output cpft_pkg::t_geom_res o_res
);

    localparam int CW   = cpft_pkg::CoordW;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int QW   = 2 * CW;
    localparam int AccW = QW + 2 + $clog2(MAX_VERTICES);

    cpft_pkg::t_vertex r_w0;
    cpft_pkg::t_vertex r_w1;

    logic signed [CW-1:0] w0_x, w0_y, w1_x, w1_y, cur_x, cur_y;
    logic signed [DW-1:0] n_ax, n_ay, n_bx, n_by;

    // Stage one: edge vectors and area operands.
    logic                 r_s1_vld, r_s1_area, r_s1_cross;
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [CW-1:0] r_xp, r_yp, r_xc, r_yc;

    // Stage two: products.
    logic                 r_s2_vld, r_s2_area, r_s2_cross;
    logic signed [PW-1:0] r_p_ab, r_p_ba;
    logic signed [QW-1:0] r_q1, r_q2;

    // Stage three: sign flags and area sum.
    logic                   r_pos, r_neg;
    logic signed [AccW-1:0] r_acc;

    logic signed [PW:0]   cross_prod;
    logic signed [QW:0]   term;

    always_comb begin
        w0_x  = r_w0.along;
        w0_y  = r_w0.across;
        w1_x  = r_w1.along;
        w1_y  = r_w1.across;
        cur_x = i_vtx.along;
        cur_y = i_vtx.across;
        n_ax  = DW'(w1_x) - DW'(w0_x);
        n_ay  = DW'(w1_y) - DW'(w0_y);
        n_bx  = DW'(cur_x) - DW'(w1_x);
        n_by  = DW'(cur_y) - DW'(w1_y);
        cross_prod = (PW+1)'(r_p_ab) - (PW+1)'(r_p_ba);
        term  = (QW+1)'(r_q1) - (QW+1)'(r_q2);
    end

    // Window and datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.sample) begin
            r_w0 <= r_w1;
            r_w1 <= i_vtx;
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_bx <= n_bx;
            r_by <= n_by;
            r_xp <= w1_x;
            r_yp <= w1_y;
            r_xc <= cur_x;
            r_yc <= cur_y;
        end
        if (r_s1_vld) begin
            r_p_ab <= r_ax * r_by;
            r_p_ba <= r_ay * r_bx;
            r_q1   <= r_xp * r_yc;
            r_q2   <= r_xc * r_yp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_s1_vld   <= 1'b0;
            r_s1_area  <= 1'b0;
            r_s1_cross <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s2_area  <= 1'b0;
            r_s2_cross <= 1'b0;
            r_pos      <= 1'b0;
            r_neg      <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s1_vld   <= i_ctl.sample;
            r_s1_area  <= i_ctl.sample & i_ctl.area;
            r_s1_cross <= i_ctl.sample & i_ctl.turn;
            r_s2_vld   <= r_s1_vld;
            r_s2_area  <= r_s1_area;
            r_s2_cross <= r_s1_cross;
            // Skip collinear triples; note the sign of every other one.
            if (r_s2_cross && (cross_prod != '0)) begin
                if (cross_prod[PW]) begin
                    r_neg <= 1'b1;
                end else begin
                    r_pos <= 1'b1;
                end
            end
            if (r_s2_area) begin
                r_acc <= r_acc + AccW'(term);
            end
        end
    end

    assign o_res.idle     = ~(r_s1_vld | r_s2_vld);
    assign o_res.convex   = r_pos ^ r_neg;
    assign o_res.area_neg = r_acc[AccW-1];

endmodule

[design/convex_polygon_fan_triangulate.sv]
// Top level of the convex polygon fan triangulator.
//
// Loads one polygon outline, one vertex per beat, and answers on the beat
// flagged vertex_last. Vertices are taken one per clock while busy is low.
// The last vertex raises busy; the block then reads the outline back from
// the vertex store in one pass of n+2 reads (every vertex, then the first
// two again) that feeds the edge cross products and the signed area sum
// through a three-stage pipeline, and a second pass of n reads (the fan
// apex, then the rim vertices in emission order) that streams out the n-2
// fan triangles one per clock. A polygon of n vertices keeps busy high
// through the read pass, the pipeline drain, the emission pass and a tail
// state for the last triangle. An overflow or a too-short outline is busy
// only in its status state, a non-convex outline also through the read
// pass and the drain. The passes share the single read port. Results are
// shown for exactly one cycle with o_res_strobe, in the cycle after they
// are formed, and cannot be held off: the receiver takes every beat. The
// last result of a polygon carries run_last. A rejected outline (fewer than
// three vertices, not convex, or all collinear) gives one beat with the
// reject status; vertices beyond MAX_VERTICES are dropped and the polygon
// answers with one overflow beat. Clockwise outlines (negative area) are
// walked in reverse so that every triangle keeps one winding. The fill
// colour register is written through the cfg channel, taken only while the
// block is idle: not busy, no vertex offered and no result on the ports.
// Write and read passes never touch the store in the
// same cycle, so no forwarding is needed. The store needs no clearing pass:
// only entries written for the current polygon are read.
module convex_polygon_fan_triangulate #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cpft_pkg::t_vertex_in i_vertex,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [cpft_pkg::ColourW-1:0] i_cfg_data,
    output logic                 o_res_strobe,
    output cpft_pkg::t_result    o_result
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CntW = $clog2(MAX_VERTICES + 2);

    cpft_pkg::t_state r_state, n_state;

    // Load bookkeeping.
    logic [CntW-1:0] r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CntW-1:0] r_n, n_n;
    logic            r_rev, n_rev;

    // Shared pass index and the tags that travel with each read.
    logic [CntW-1:0] r_idx, n_idx;
    logic            r_tag_walk, n_tag_walk;
    logic            r_tag_area, n_tag_area;
    logic            r_tag_cross, n_tag_cross;
    logic            r_tag_emit, n_tag_emit;
    logic            r_tag_final, n_tag_final;
    logic [CntW-1:0] r_tag_idx, n_tag_idx;

    // Fan apex, previous rim vertex, result register.
    cpft_pkg::t_vertex r_p0, n_p0;
    cpft_pkg::t_vertex r_pa, n_pa;
    cpft_pkg::t_result r_out, n_out;
    logic              r_out_vld, n_out_vld;

    logic [cpft_pkg::ColourW-1:0] r_colour;

    logic              accept;
    logic              last_beat;
    logic              room;
    logic [CntW-1:0]   n_after;
    logic              ovf_now;

    logic              mem_wr;
    logic              mem_rd;
    logic [AW-1:0]     rd_addr;
    logic [CntW-1:0]   wrap_idx;
    cpft_pkg::t_vertex wr_data;
    cpft_pkg::t_vertex rd_data;

    cpft_pkg::t_geom_ctl geom_ctl;
    cpft_pkg::t_geom_res geom_res;

    cpft_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (mem_rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cpft_geom #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (geom_ctl),
        .i_vtx   (rd_data),
        .o_res   (geom_res)
    );

    assign busy        = (r_state != cpft_pkg::S_LOAD);
    // Hold off colour writes while a vertex is offered or a result is shown.
    assign o_cfg_ready = ~busy & ~start & ~r_out_vld;
    assign accept      = start & ~busy;
    assign last_beat = accept & i_vertex.vertex_last;
    assign room      = (r_count < CntW'(MAX_VERTICES));
    assign n_after   = room ? (r_count + CntW'(1)) : r_count;
    assign ovf_now   = r_ovf | ~room;

    assign wr_data.along  = i_vertex.vertex_along;
    assign wr_data.across = i_vertex.vertex_across;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cpft_pkg::S_LOAD: begin
                if (last_beat) begin
                    if (ovf_now) begin
                        n_state = cpft_pkg::S_OVF;
                    end else if (n_after < CntW'(cpft_pkg::MinVertices)) begin
                        n_state = cpft_pkg::S_REJECT;
                    end else begin
                        n_state = cpft_pkg::S_WALK;
                    end
                end
            end
            cpft_pkg::S_WALK: begin
                if (r_idx == r_n + CntW'(1)) begin
                    n_state = cpft_pkg::S_DRAIN;
                end
            end
            cpft_pkg::S_DRAIN: begin
                if (!r_tag_walk && geom_res.idle) begin
                    n_state = geom_res.convex ? cpft_pkg::S_EMIT : cpft_pkg::S_REJECT;
                end
            end
            cpft_pkg::S_EMIT: begin
                if (r_idx == r_n - CntW'(1)) begin
                    n_state = cpft_pkg::S_TAIL;
                end
            end
            cpft_pkg::S_TAIL:   n_state = cpft_pkg::S_LOAD;
            cpft_pkg::S_OVF:    n_state = cpft_pkg::S_LOAD;
            cpft_pkg::S_REJECT: n_state = cpft_pkg::S_LOAD;
            default:            n_state = cpft_pkg::S_LOAD;
        endcase
    end

    // Datapath control and result assembly.
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_rev       = r_rev;
        n_idx       = r_idx;
        n_tag_walk  = 1'b0;
        n_tag_area  = 1'b0;
        n_tag_cross = 1'b0;
        n_tag_emit  = 1'b0;
        n_tag_final = 1'b0;
        n_tag_idx   = r_idx;
        n_p0        = r_p0;
        n_pa        = r_pa;
        n_out       = r_out;
        n_out_vld   = 1'b0;
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        wrap_idx    = r_idx - r_n;
        geom_ctl    = '0;

        case (r_state)
            cpft_pkg::S_LOAD: begin
                if (accept) begin
                    mem_wr  = room;
                    n_count = n_after;
                    n_ovf   = ovf_now;
                end
                if (last_beat) begin
                    // Latch the outline size and rearm for the next polygon.
                    n_n            = n_after;
                    n_count        = '0;
                    n_ovf          = 1'b0;
                    n_idx          = '0;
                    geom_ctl.clear = 1'b1;
                end
            end
            cpft_pkg::S_WALK: begin
                // Read every vertex, then the first two again for the wrap.
                mem_rd      = 1'b1;
                rd_addr     = (r_idx < r_n) ? r_idx[AW-1:0] : wrap_idx[AW-1:0];
                n_tag_walk  = 1'b1;
                n_tag_area  = (r_idx != '0) && (r_idx <= r_n);
                n_tag_cross = (r_idx >= CntW'(2));
                n_idx       = r_idx + CntW'(1);
            end
            cpft_pkg::S_DRAIN: begin
                n_idx = '0;
                n_rev = geom_res.area_neg;
            end
            cpft_pkg::S_EMIT: begin
                // Apex first, then the rim in winding order.
                mem_rd = 1'b1;
                if (!r_rev) begin
                    rd_addr = r_idx[AW-1:0];
                end else if (r_idx == '0) begin
                    wrap_idx = r_n - CntW'(1);
                    rd_addr  = wrap_idx[AW-1:0];
                end else begin
                    wrap_idx = r_n - CntW'(1) - r_idx;
                    rd_addr  = wrap_idx[AW-1:0];
                end
                n_tag_emit  = 1'b1;
                n_tag_final = (r_idx == r_n - CntW'(1));
                n_idx       = r_idx + CntW'(1);
            end
            cpft_pkg::S_OVF: begin
                n_out          = '0;
                n_out.status   = cpft_pkg::ST_OVERFLOW;
                n_out.run_last = 1'b1;
                n_out_vld      = 1'b1;
            end
            cpft_pkg::S_REJECT: begin
                n_out          = '0;
                n_out.status   = cpft_pkg::ST_REJECT;
                n_out.run_last = 1'b1;
                n_out_vld      = 1'b1;
            end
            default: begin
            end
        endcase

        geom_ctl.sample = r_tag_walk;
        geom_ctl.area   = r_tag_area;
        geom_ctl.turn   = r_tag_cross;

        // Emission pass: hold apex, then rim vertex, then one triangle a beat.
        if (r_tag_emit) begin
            if (r_tag_idx == '0) begin
                n_p0 = rd_data;
            end else if (r_tag_idx == CntW'(1)) begin
                n_pa = rd_data;
            end else begin
                n_pa                = rd_data;
                n_out.first_along   = r_p0.along;
                n_out.first_across  = r_p0.across;
                n_out.second_along  = r_pa.along;
                n_out.second_across = r_pa.across;
                n_out.third_along   = rd_data.along;
                n_out.third_across  = rd_data.across;
                n_out.colour        = r_colour;
                n_out.status        = cpft_pkg::ST_TRI;
                n_out.run_last      = r_tag_final;
                n_out_vld           = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpft_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_tag_walk  <= 1'b0;
            r_tag_area  <= 1'b0;
            r_tag_cross <= 1'b0;
            r_tag_emit  <= 1'b0;
            r_tag_final <= 1'b0;
            r_out_vld   <= 1'b0;
            r_colour    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_tag_walk  <= n_tag_walk;
            r_tag_area  <= n_tag_area;
            r_tag_cross <= n_tag_cross;
            r_tag_emit  <= n_tag_emit;
            r_tag_final <= n_tag_final;
            r_out_vld   <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_colour <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_rev     <= n_rev;
        r_idx     <= n_idx;
        r_tag_idx <= n_tag_idx;
        r_p0      <= n_p0;
        r_pa      <= n_pa;
        r_out     <= n_out;
    end

    assign o_res_strobe = r_out_vld;
    assign o_result     = r_out;

endmodule

[design/cpft_checker.sv]
// Port-level checker of the fan triangulator and its bind.
`include "convex_polygon_fan_triangulate_defines.svh"

module cpft_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input cpft_pkg::t_vertex_in i_vertex,
    input logic                 o_res_strobe,
    input cpft_pkg::t_result    o_result
);

    // A status beat always closes its polygon.
    `CPFT_ASSERT_SAME(a_status_last, i_clk, i_rst_n, o_res_strobe && (o_result.status != cpft_pkg::ST_TRI), o_result.run_last, "status beat without run_last")

    // A status beat carries no colour.
    `CPFT_ASSERT_SAME(a_status_colour, i_clk, i_rst_n, o_res_strobe && (o_result.status != cpft_pkg::ST_TRI), o_result.colour == '0, "status beat with colour")

    // Triangles of one polygon stream without gaps.
    `CPFT_ASSERT_NEXT(a_fan_stream, i_clk, i_rst_n, o_res_strobe && !o_result.run_last, o_res_strobe, "gap inside a triangle run")

    // A taken last vertex makes the block busy.
    `CPFT_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, start && !busy && i_vertex.vertex_last, busy, "last vertex did not start processing")

    // A closing beat is never followed at once by another beat.
    `CPFT_ASSERT_NEXT(a_run_gap, i_clk, i_rst_n, o_res_strobe && o_result.run_last, !o_res_strobe, "beat right after run_last")

endmodule

bind convex_polygon_fan_triangulate cpft_checker u_cpft_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_vertex     (i_vertex),
    .o_res_strobe (o_res_strobe),
    .o_result     (o_result)
);
